### hw/rtl/scc_pkg.sv
// ----------------------------------------------------------------------------
// System control coprocessor package
// Shared opcodes, register indexes, masks and structures.
// ----------------------------------------------------------------------------
package scc_pkg;

  typedef enum logic [2:0] {
    OP_READ   = 3'd0,
    OP_WRITE  = 3'd1,
    OP_EXC    = 3'd2,
    OP_RFE    = 3'd3,
    OP_SETPND = 3'd4
  } op_e;

  localparam logic [4:0] IDX_BADVADDR = 5'd8;
  localparam logic [4:0] IDX_STATUS   = 5'd12;
  localparam logic [4:0] IDX_CAUSE    = 5'd13;
  localparam logic [4:0] IDX_EPC      = 5'd14;
  localparam logic [4:0] IDX_PRID     = 5'd15;

  localparam logic [31:0] PRID_VALUE  = 32'h0000_0002;
  localparam logic [31:0] CA_SW_MASK  = 32'h0000_0300;
  localparam logic [31:0] IP_MASK     = 32'h0000_0700;
  localparam logic [31:0] EPC_STEP    = 32'd4;

  localparam int unsigned ST_IEC_BIT  = 0;
  localparam int unsigned ST_IM2_BIT  = 10;
  localparam int unsigned ST_COP2_BIT = 30;
  localparam int unsigned CA_PND_BIT  = 10;
  localparam int unsigned CA_BD_BIT   = 31;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [4:0]  reg_index;
    logic [31:0] write_value;
    logic [4:0]  exc_code;
    logic [31:0] pc;
    logic        in_delay_slot;
    logic        has_bad_vaddr;
    logic [31:0] bad_vaddr;
    logic        irq_pending;
  } req_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        take_interrupt;
    logic        in_exception_mode;
    logic        cop2_enabled;
    logic        irq_enable_hw0;
  } rsp_t;

  typedef struct packed {
    logic [31:0] bad_vaddr;
    logic [31:0] status;
    logic [31:0] cause;
    logic [31:0] epc;
  } cop_state_t;

endpackage

### hw/rtl/scc_if.sv
// ----------------------------------------------------------------------------
// System control coprocessor channels
// Request and response channels with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface scc_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  opcode;
  logic [4:0]  reg_index;
  logic [31:0] write_value;
  logic [4:0]  exc_code;
  logic [31:0] pc;
  logic        in_delay_slot;
  logic        has_bad_vaddr;
  logic [31:0] bad_vaddr;
  logic        irq_pending;

  modport source (
    output valid, opcode, reg_index, write_value, exc_code, pc,
           in_delay_slot, has_bad_vaddr, bad_vaddr, irq_pending,
    input  ready
  );
  modport sink (
    input  valid, opcode, reg_index, write_value, exc_code, pc,
           in_delay_slot, has_bad_vaddr, bad_vaddr, irq_pending,
    output ready
  );
endinterface

interface scc_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic        take_interrupt;
  logic        in_exception_mode;
  logic        cop2_enabled;
  logic        irq_enable_hw0;

  modport source (
    output valid, read_data, take_interrupt, in_exception_mode,
           cop2_enabled, irq_enable_hw0,
    input  ready
  );
  modport sink (
    input  valid, read_data, take_interrupt, in_exception_mode,
           cop2_enabled, irq_enable_hw0,
    output ready
  );
endinterface

### hw/rtl/scc_exec.sv
// ----------------------------------------------------------------------------
// System control coprocessor execute logic
// Computes the next register state and the response flags for one request.
// ----------------------------------------------------------------------------
module scc_exec (
  input  scc_pkg::cop_state_t cur_i,
  input  scc_pkg::req_t       req_i,
  output scc_pkg::cop_state_t nxt_o,
  output scc_pkg::rsp_t       rsp_o
);
  import scc_pkg::*;

  cop_state_t  nxt;
  logic [31:0] rd;
  logic        exc_mode;
  logic        iec;

  always_comb begin
    nxt = cur_i;
    rd  = '0;
    unique case (req_i.opcode)
      OP_READ: begin
        unique case (req_i.reg_index)
          IDX_BADVADDR: rd = cur_i.bad_vaddr;
          IDX_STATUS:   rd = cur_i.status;
          IDX_CAUSE:    rd = cur_i.cause;
          IDX_EPC:      rd = cur_i.epc;
          IDX_PRID:     rd = PRID_VALUE;
          default:      rd = '0;
        endcase
      end
      OP_WRITE: begin
        unique case (req_i.reg_index)
          IDX_BADVADDR: nxt.bad_vaddr = req_i.write_value;
          IDX_STATUS:   nxt.status    = req_i.write_value;
          IDX_CAUSE:    nxt.cause     = (cur_i.cause & ~CA_SW_MASK)
                                        | (req_i.write_value & CA_SW_MASK);
          IDX_EPC:      nxt.epc       = req_i.write_value;
          default:      nxt = cur_i;
        endcase
      end
      OP_EXC: begin
        // Push the kernel/user and interrupt-enable stack by one level.
        nxt.status[5:0]      = {cur_i.status[3:0], 2'b00};
        nxt.cause[6:2]       = req_i.exc_code;
        nxt.cause[CA_BD_BIT] = req_i.in_delay_slot;
        nxt.epc = req_i.in_delay_slot ? (req_i.pc - EPC_STEP) : req_i.pc;
        if (req_i.has_bad_vaddr) begin
          nxt.bad_vaddr = req_i.bad_vaddr;
        end
      end
      OP_RFE: begin
        // Pop the stack; the oldest level keeps its value.
        nxt.status[3:0] = cur_i.status[5:2];
      end
      OP_SETPND: begin
        nxt.cause[CA_PND_BIT] = req_i.irq_pending;
      end
      default: nxt = cur_i;
    endcase
  end

  // Flags always reflect the state after the operation.
  assign exc_mode = (nxt.status[1:0] == 2'b00) && (nxt.status[5:2] != 4'b0000);
  assign iec      = nxt.status[ST_IEC_BIT];

  assign nxt_o = nxt;
  assign rsp_o.read_data         = rd;
  assign rsp_o.take_interrupt    = !exc_mode && iec
                                   && ((nxt.cause & nxt.status & IP_MASK) != '0);
  assign rsp_o.in_exception_mode = exc_mode;
  assign rsp_o.cop2_enabled      = nxt.status[ST_COP2_BIT];
  assign rsp_o.irq_enable_hw0    = iec && nxt.status[ST_IM2_BIT];

endmodule

### hw/rtl/system_control_coprocessor_core.sv
// ----------------------------------------------------------------------------
// System control coprocessor core
// Holds BadVAddr, Status, Cause and EPC and executes one operation per request.
// ----------------------------------------------------------------------------
// Usage: the processor issues one request transaction per operation on req_i:
// read, write, exception entry, return from exception, or an update of the
// interrupt-controller pending bit in Cause. Every request yields exactly one
// response transaction on rsp_o with the read data (zero except for reads)
// and four status flags computed from the register state after the operation.
// Path: a request accepted at a clock edge is registered in the input stage,
// evaluated by the execute logic, and its response is registered in the
// response register once that register is free or being emptied.
// Throughput: one transaction per cycle while rsp_o.ready is high; state is
// updated as each request leaves the input stage, so a following request sees it.
// Reset: all four registers clear to zero and both stages empty.
// Stall: when rsp_o.ready is low the response is held; the input stage keeps
// accepting until it is full too, then req_i.ready drops. No transaction is
// lost or repeated.
// ----------------------------------------------------------------------------
module system_control_coprocessor_core (
  input  logic  clk_i,
  input  logic  rst_ni,
  scc_req_if.sink   req_i,
  scc_rsp_if.source rsp_o
);
  import scc_pkg::*;

  req_t       req_d, req_q;
  logic       s1_valid_q;
  rsp_t       rsp_d, rsp_q;
  logic       out_valid_q;
  cop_state_t state_q, state_d;
  logic       s1_advance;
  logic       in_fire;

  // The input stage moves forward whenever the response register is free
  // or is being emptied in this cycle.
  assign s1_advance   = !out_valid_q || rsp_o.ready;
  assign req_i.ready  = !s1_valid_q || s1_advance;
  assign in_fire      = req_i.valid && req_i.ready;

  always_comb begin
    req_d.opcode        = req_i.opcode;
    req_d.reg_index     = req_i.reg_index;
    req_d.write_value   = req_i.write_value;
    req_d.exc_code      = req_i.exc_code;
    req_d.pc            = req_i.pc;
    req_d.in_delay_slot = req_i.in_delay_slot;
    req_d.has_bad_vaddr = req_i.has_bad_vaddr;
    req_d.bad_vaddr     = req_i.bad_vaddr;
    req_d.irq_pending   = req_i.irq_pending;
  end

  scc_exec u_exec (
    .cur_i (state_q),
    .req_i (req_q),
    .nxt_o (state_d),
    .rsp_o (rsp_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      if (req_i.ready) begin
        s1_valid_q <= req_i.valid;
      end
      if (s1_advance) begin
        out_valid_q <= s1_valid_q;
      end
      if (s1_valid_q && s1_advance) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      req_q <= req_d;
    end
    if (s1_valid_q && s1_advance) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_o.valid             = out_valid_q;
  assign rsp_o.read_data         = rsp_q.read_data;
  assign rsp_o.take_interrupt    = rsp_q.take_interrupt;
  assign rsp_o.in_exception_mode = rsp_q.in_exception_mode;
  assign rsp_o.cop2_enabled      = rsp_q.cop2_enabled;
  assign rsp_o.irq_enable_hw0    = rsp_q.irq_enable_hw0;

endmodule

### tb/sv/system_control_coprocessor_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// System control coprocessor core testbench
// Drives read, write, exception entry, return-from-exception and pending-bit
// transactions into the core, predicts every response from a shadow copy of
// the coprocessor registers and compares each response field by field.
// ----------------------------------------------------------------------------
module system_control_coprocessor_core_tb;
  import scc_pkg::*;

  // Timing of the run. The limit is far above the slowest legal run, with both
  // sides idling hard.
  localparam int unsigned HALF_PERIOD     = 10;
  localparam int unsigned RESET_CYCLES    = 11;
  localparam int unsigned DRAIN_CYCLES    = 8;
  localparam int unsigned CYCLE_LIMIT     = 200000;
  localparam int unsigned MAX_REPORTED    = 10;
  localparam int unsigned ITEMS_PER_PHASE = 325;

  // Opcodes past the last defined one; the core must treat them as no-ops.
  localparam logic [2:0] OP_UNUSED_LO = 3'd5;
  localparam logic [2:0] OP_UNUSED_HI = 3'd7;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  scc_req_if req_if ();
  scc_rsp_if rsp_if ();

  // Shadow copy of BadVAddr, Status, Cause and EPC as the core should hold them
  // after every accepted request, and the responses still owed by the core.
  cop_state_t  shadow_regs = '0;
  rsp_t        expected_rsp_q [$];

  int unsigned mismatch_count     = 0;
  int unsigned cycle_count        = 0;
  int unsigned sender_idle_pct    = 0;
  int unsigned receiver_stall_pct = 0;

  always #(HALF_PERIOD) clk = ~clk;

  system_control_coprocessor_core u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // Applies one request to the shadow registers and returns the response the
  // core owes for it. The four flags are always taken from the state after
  // the operation, so they reflect what the request just did.
  function automatic rsp_t predict_response(input req_t r);
    rsp_t       rsp;
    logic [5:0] mode;
    logic       exc_mode;

    rsp = '0;
    case (r.opcode)
      OP_READ: begin
        case (r.reg_index)
          IDX_BADVADDR: rsp.read_data = shadow_regs.bad_vaddr;
          IDX_STATUS:   rsp.read_data = shadow_regs.status;
          IDX_CAUSE:    rsp.read_data = shadow_regs.cause;
          IDX_EPC:      rsp.read_data = shadow_regs.epc;
          IDX_PRID:     rsp.read_data = PRID_VALUE;
          default:      rsp.read_data = '0;
        endcase
      end
      OP_WRITE: begin
        // Software may only touch the two software interrupt bits of Cause;
        // writes to any register outside the four kept ones are dropped.
        case (r.reg_index)
          IDX_BADVADDR: shadow_regs.bad_vaddr = r.write_value;
          IDX_STATUS:   shadow_regs.status = r.write_value;
          IDX_CAUSE: begin
            shadow_regs.cause = (shadow_regs.cause & ~CA_SW_MASK) |
                                (r.write_value & CA_SW_MASK);
          end
          IDX_EPC:      shadow_regs.epc = r.write_value;
          default: ;
        endcase
      end
      OP_EXC: begin
        // Push the KU/IE stack: old <- previous <- current, current cleared.
        mode = {shadow_regs.status[3:0], 2'b00};
        shadow_regs.status[5:0] = mode;
        shadow_regs.cause[6:2] = r.exc_code;
        shadow_regs.cause[CA_BD_BIT] = r.in_delay_slot;
        // In a delay slot EPC points at the branch, one word back; the
        // subtraction wraps around at address zero.
        shadow_regs.epc = r.in_delay_slot ? r.pc - EPC_STEP : r.pc;
        if (r.has_bad_vaddr) begin
          shadow_regs.bad_vaddr = r.bad_vaddr;
        end
      end
      OP_RFE: begin
        // Pop the stack; the old pair keeps its value.
        shadow_regs.status[3:0] = shadow_regs.status[5:2];
      end
      OP_SETPND: begin
        shadow_regs.cause[CA_PND_BIT] = r.irq_pending;
      end
      default: ;
    endcase

    exc_mode = (shadow_regs.status[1:0] == 2'b00) && (shadow_regs.status[5:0] != 6'd0);
    rsp.in_exception_mode = exc_mode;
    rsp.take_interrupt = !exc_mode && shadow_regs.status[ST_IEC_BIT] &&
                         ((shadow_regs.cause & shadow_regs.status & IP_MASK) != '0);
    rsp.cop2_enabled = shadow_regs.status[ST_COP2_BIT];
    rsp.irq_enable_hw0 = shadow_regs.status[ST_IEC_BIT] && shadow_regs.status[ST_IM2_BIT];
    return rsp;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // A request with every field random. Opcodes lean toward the defined ones
  // and register numbers toward the implemented registers, so that the
  // exception stack and the interrupt logic see long, meaningful sequences;
  // the remaining indexes and the unused opcodes still come up regularly.
  function automatic req_t random_request();
    req_t        r;
    int unsigned pick;

    r.opcode        = OP_READ;
    r.reg_index     = 5'($urandom_range(0, 31));
    r.write_value   = $urandom();
    r.exc_code      = 5'($urandom_range(0, 31));
    r.pc            = $urandom();
    r.in_delay_slot = 1'($urandom_range(0, 1));
    r.has_bad_vaddr = 1'($urandom_range(0, 1));
    r.bad_vaddr     = $urandom();
    r.irq_pending   = 1'($urandom_range(0, 1));

    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      r.opcode = OP_READ;
    end else if (pick < 55) begin
      r.opcode = OP_WRITE;
    end else if (pick < 70) begin
      r.opcode = OP_EXC;
    end else if (pick < 82) begin
      r.opcode = OP_RFE;
    end else if (pick < 95) begin
      r.opcode = OP_SETPND;
    end else begin
      r.opcode = 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
    end

    if ($urandom_range(0, 9) < 7) begin
      case ($urandom_range(0, 4))
        0: r.reg_index = IDX_BADVADDR;
        1: r.reg_index = IDX_STATUS;
        2: r.reg_index = IDX_CAUSE;
        3: r.reg_index = IDX_EPC;
        default: r.reg_index = IDX_PRID;
      endcase
    end

    // Enabling interrupts more often than chance gives take_interrupt a fair
    // number of high responses.
    if (r.opcode == OP_WRITE && r.reg_index == IDX_STATUS && $urandom_range(0, 1) != 0) begin
      r.write_value[ST_IEC_BIT] = 1'b1;
    end
    return r;
  endfunction

  // Offers one request transaction, with an optional idle gap before it, and
  // waits for the core to take it. The task always returns in the time step
  // of the accepting edge, so valid stays high into the next request unless
  // that one starts with a gap.
  task automatic send_request(input req_t r);
    int unsigned gap;

    gap = 0;
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      gap++;
    end
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end

    req_if.valid         <= 1'b1;
    req_if.opcode        <= r.opcode;
    req_if.reg_index     <= r.reg_index;
    req_if.write_value   <= r.write_value;
    req_if.exc_code      <= r.exc_code;
    req_if.pc            <= r.pc;
    req_if.in_delay_slot <= r.in_delay_slot;
    req_if.has_bad_vaddr <= r.has_bad_vaddr;
    req_if.bad_vaddr     <= r.bad_vaddr;
    req_if.irq_pending   <= r.irq_pending;

    do @(posedge clk); while (!req_if.ready);
    expected_rsp_q.push_back(predict_response(r));
  endtask

  // --------------------------------------------------------------------------
  // Response checking
  // --------------------------------------------------------------------------

  task automatic check_response();
    rsp_t got;
    rsp_t want;

    got = '{read_data:         rsp_if.read_data,
            take_interrupt:    rsp_if.take_interrupt,
            in_exception_mode: rsp_if.in_exception_mode,
            cop2_enabled:      rsp_if.cop2_enabled,
            irq_enable_hw0:    rsp_if.irq_enable_hw0};

    if (expected_rsp_q.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTED) begin
        $display("%0t: response transaction with none outstanding: rd=%h take=%b exc=%b cop2=%b hw0=%b",
                 $realtime, got.read_data, got.take_interrupt, got.in_exception_mode,
                 got.cop2_enabled, got.irq_enable_hw0);
      end
    end else begin
      want = expected_rsp_q.pop_front();
      if (got.read_data !== want.read_data ||
          got.take_interrupt !== want.take_interrupt ||
          got.in_exception_mode !== want.in_exception_mode ||
          got.cop2_enabled !== want.cop2_enabled ||
          got.irq_enable_hw0 !== want.irq_enable_hw0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTED) begin
          $display("%0t: response mismatch: expected rd=%h take=%b exc=%b cop2=%b hw0=%b",
                   $realtime, want.read_data, want.take_interrupt, want.in_exception_mode,
                   want.cop2_enabled, want.irq_enable_hw0);
          $display("%0t:                    actual rd=%h take=%b exc=%b cop2=%b hw0=%b",
                   $realtime, got.read_data, got.take_interrupt, got.in_exception_mode,
                   got.cop2_enabled, got.irq_enable_hw0);
        end
      end
    end
  endtask

  // The response side: every edge it checks a completed transaction and then
  // decides whether to stall the next cycle. Both happen in one process so
  // the ready it samples is the one it drove for that edge.
  initial begin
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && rsp_if.valid && rsp_if.ready) begin
        check_response();
      end
      rsp_if.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end
  end

  // A hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[system_control_coprocessor_core] ERROR");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reads straight after reset: the four kept registers must be zero, PRId
  // reads its fixed value and unimplemented indexes at both ends read zero.
  task automatic test_register_reads();
    req_t       r;
    logic [4:0] read_list [7];

    read_list = '{IDX_BADVADDR, IDX_STATUS, IDX_CAUSE, IDX_EPC, IDX_PRID, 5'd0, 5'd31};
    foreach (read_list[i]) begin
      r = random_request();
      r.opcode = OP_READ;
      r.reg_index = read_list[i];
      send_request(r);
    end
  endtask

  // Writes with all ones and all zeros. Status all ones enables every
  // interrupt source and COP2; a Cause write of all ones may only set the
  // software bits, which then raise take_interrupt. A write to PRId must not
  // change what it reads.
  task automatic test_register_writes();
    req_t r;

    r = random_request();
    r.opcode = OP_WRITE;
    r.reg_index = IDX_STATUS;
    r.write_value = '1;
    send_request(r);
    r.opcode = OP_READ;
    send_request(r);

    r.opcode = OP_WRITE;
    r.reg_index = IDX_CAUSE;
    send_request(r);
    r.opcode = OP_READ;
    send_request(r);

    r.opcode = OP_WRITE;
    r.reg_index = IDX_BADVADDR;
    send_request(r);

    r.reg_index = IDX_EPC;
    r.write_value = '0;
    send_request(r);

    r.reg_index = IDX_PRID;
    r.write_value = '1;
    send_request(r);
    r.opcode = OP_READ;
    send_request(r);
  endtask

  // Exception entry in a delay slot at address zero, so EPC wraps to the top
  // of the address space, with the largest cause code and a BadVAddr load;
  // then a second entry outside a delay slot at the highest address with no
  // BadVAddr load. The first entry puts the core into exception mode.
  task automatic test_exception_entry();
    req_t r;

    r = random_request();
    r.opcode = OP_EXC;
    r.exc_code = '1;
    r.pc = '0;
    r.in_delay_slot = 1'b1;
    r.has_bad_vaddr = 1'b1;
    r.bad_vaddr = '1;
    send_request(r);

    r.opcode = OP_READ;
    r.reg_index = IDX_EPC;
    send_request(r);

    r.opcode = OP_EXC;
    r.exc_code = '0;
    r.pc = '1;
    r.in_delay_slot = 1'b0;
    r.has_bad_vaddr = 1'b0;
    r.bad_vaddr = '0;
    send_request(r);
  endtask

  // Two returns unwind the two entries above: the first leaves the core still
  // in exception mode, the second brings back the enabled state.
  task automatic test_return_from_exception();
    req_t r;

    r = random_request();
    r.opcode = OP_RFE;
    send_request(r);
    send_request(r);
  endtask

  task automatic test_pending_bit();
    req_t r;

    r = random_request();
    r.opcode = OP_SETPND;
    r.irq_pending = 1'b1;
    send_request(r);
    r.irq_pending = 1'b0;
    send_request(r);
  endtask

  task automatic test_unused_opcodes();
    req_t r;

    for (int op = OP_UNUSED_LO; op <= OP_UNUSED_HI; op++) begin
      r = random_request();
      r.opcode = 3'(op);
      send_request(r);
    end
  endtask

  // Random traffic in four idling phases: none, a mostly idle sender, a
  // mostly stalled receiver, and both sides idling now and then.
  task automatic test_random_traffic();
    int unsigned sender_plan [4];
    int unsigned stall_plan [4];

    sender_plan = '{0, 82, 0, 20};
    stall_plan  = '{0, 0, 82, 20};
    for (int phase = 0; phase < 4; phase++) begin
      sender_idle_pct = sender_plan[phase];
      receiver_stall_pct = stall_plan[phase];
      repeat (ITEMS_PER_PHASE) send_request(random_request());
    end
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------

  initial begin
    req_if.valid         <= 1'b0;
    req_if.opcode        <= OP_READ;
    req_if.reg_index     <= '0;
    req_if.write_value   <= '0;
    req_if.exc_code      <= '0;
    req_if.pc            <= '0;
    req_if.in_delay_slot <= 1'b0;
    req_if.has_bad_vaddr <= 1'b0;
    req_if.bad_vaddr     <= '0;
    req_if.irq_pending   <= 1'b0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    test_register_reads();
    test_register_writes();
    test_exception_entry();
    test_return_from_exception();
    test_pending_bit();
    test_unused_opcodes();
    test_random_traffic();

    // All requests are in; let the core return what it still owes, then wait out
    // DRAIN_CYCLES so that any response transaction it should not send shows up.
    req_if.valid <= 1'b0;
    while (expected_rsp_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("[system_control_coprocessor_core] OK");
    end else begin
      $display("[system_control_coprocessor_core] ERROR");
    end
    $finish;
  end

endmodule
